// ===== design/imm_pkg.sv =====
`default_nettype none
package imm_pkg;

    localparam int ROWS  = 8;
    localparam int INNER = 8;
    localparam int COLS  = 8;

    localparam int K_W   = (INNER > 1) ? $clog2(INNER) : 1;
    localparam int C_W   = 3;
    localparam int AW    = (ROWS * INNER > 1) ? $clog2(ROWS * INNER) : 1;
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam int BW    = $clog2(8 * ROWS + 1);
    localparam int DRAIN = COLS + 3;
    localparam int DR_W  = $clog2(DRAIN + 1);

    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam logic CFG_PART_COUNT = 1'b0;
    localparam logic CFG_PART_INDEX = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] element_value;
    } req_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] product_value;
        logic               last_of_band;
    } rsp_t;

    typedef struct packed {
        logic             we;
        logic [K_W-1:0]   k;
        logic [C_W-1:0]   col;
        logic [31:0]      data;
    } bload_t;

    typedef struct packed {
        logic             valid;
        logic [K_W-1:0]   k;
        logic [31:0]      a;
    } link_t;

endpackage
`default_nettype wire

// ===== design/integer_matrix_multiply.sv =====
// A load writes its store when accepted. A compute runs a band-bound search and a setup
// step, then per band row feeds the A row into the cell chain, drains the chain and emits
// the row one element at a time, waiting while the output stalls.
// Throughput: loads one per cycle while the engine is idle; a compute holds the engine,
// stalling requests, until its band is emitted; the single A read port feeds the cell chain.
// Reset: asynchronous active-low; part_count 1, part_index 0; stores kept.
`default_nettype none
module integer_matrix_multiply (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [3:0]    cfg_data,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire imm_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output imm_pkg::rsp_t      rsp
);
    import imm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BOUND = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_FEED  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [3:0]       part_count_reg;
    logic [2:0]       part_index_reg;
    logic [3:0]       cnt_reg, cnt_next;
    logic [BW-1:0]    ts_reg, ts_next, tp_reg, tp_next;
    logic [BW-1:0]    macc_reg, macc_next;
    logic [ROW_W-1:0] mc_reg, mc_next;
    logic [ROW_W-1:0] start_reg, start_next, stop_reg, stop_next, row_reg, row_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [DR_W-1:0]  dr_reg, dr_next;
    logic [C_W-1:0]   ec_reg, ec_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg;

    logic [31:0]      a_mem [ROWS*INNER];
    logic [31:0]      a_rd_reg;
    logic             fv_reg;
    logic [K_W-1:0]   fk_reg;
    logic             feed;
    logic [AW-1:0]    a_addr;

    logic             accept, emit_go;
    logic [3:0]       cnt_eff;
    logic [2:0]       idx_eff;
    bload_t           bload;
    link_t            links [COLS+1];
    logic [31:0]      results [COLS];

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign emit_go   = !rsp_valid_reg || !rsp_stall;

    assign cnt_eff = (part_count_reg == 4'd0) ? 4'd1 : part_count_reg;
    assign idx_eff = ({1'b0, part_index_reg} >= cnt_eff) ? 3'(cnt_eff - 4'd1) : part_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= 4'd1;
            part_index_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PART_COUNT: part_count_reg <= cfg_data;
                CFG_PART_INDEX: part_index_reg <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // A store: one write port for loads, one registered read port feeding cell zero.
    assign feed   = (state_reg == ST_FEED);
    assign a_addr = AW'(32'(row_reg) * INNER + 32'(k_reg));

    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_LOAD_A
            && 32'(req.row_index) < ROWS && 32'(req.col_index) < INNER)
        begin
            a_mem[AW'(32'(req.row_index) * INNER + 32'(req.col_index))] <= req.element_value;
        end
        a_rd_reg <= a_mem[a_addr];
        fk_reg   <= k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= feed;
        end
    end

    always_comb
    begin
        bload.we   = accept && req.req_type == REQ_LOAD_B
                     && 32'(req.row_index) < INNER && 32'(req.col_index) < COLS;
        bload.k    = K_W'(req.row_index);
        bload.col  = req.col_index;
        bload.data = req.element_value;
    end

    assign links[0].valid = fv_reg;
    assign links[0].k     = fk_reg;
    assign links[0].a     = a_rd_reg;

    for (genvar j = 0; j < COLS; j++)
    begin : g_cell
        imm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .col_id   (C_W'(j)),
            .bload    (bload),
            .link_in  (links[j]),
            .link_out (links[j+1]),
            .result   (results[j])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ts_next        = ts_reg;
        tp_next        = tp_reg;
        macc_next      = macc_reg;
        mc_next        = mc_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        dr_next        = dr_reg;
        ec_next        = ec_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.req_type == REQ_COMPUTE)
                begin
                    cnt_next   = cnt_eff;
                    ts_next    = BW'(32'(idx_eff) * ROWS);
                    tp_next    = BW'((32'(idx_eff) + 1) * ROWS);
                    macc_next  = BW'(cnt_eff);
                    mc_next    = ROW_W'(1);
                    start_next = '0;
                    stop_next  = '0;
                    state_next = ST_BOUND;
                end
            end
            // Counts the multiples of the part count that fit under each bound,
            // which is the integer quotient.
            ST_BOUND:
            begin
                if (macc_reg <= ts_reg)
                begin
                    start_next = start_reg + ROW_W'(1);
                end
                if (macc_reg <= tp_reg)
                begin
                    stop_next = stop_reg + ROW_W'(1);
                end
                macc_next = macc_reg + BW'(cnt_reg);
                mc_next   = mc_reg + ROW_W'(1);
                if (32'(mc_reg) == ROWS)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                row_next   = start_reg;
                k_next     = '0;
                state_next = (start_reg == stop_reg) ? ST_IDLE : ST_FEED;
            end
            ST_FEED:
            begin
                k_next = k_reg + K_W'(1);
                if (32'(k_reg) == INNER - 1)
                begin
                    k_next     = '0;
                    dr_next    = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                dr_next = dr_reg + DR_W'(1);
                if (32'(dr_reg) == DRAIN - 1)
                begin
                    ec_next    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    rsp_valid_next = 1'b1;
                    ec_next        = ec_reg + C_W'(1);
                    if (32'(ec_reg) == COLS - 1)
                    begin
                        ec_next  = '0;
                        row_next = row_reg + ROW_W'(1);
                        state_next = (row_reg + ROW_W'(1) == stop_reg) ? ST_IDLE : ST_FEED;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ts_reg        <= '0;
            tp_reg        <= '0;
            macc_reg      <= '0;
            mc_reg        <= '0;
            start_reg     <= '0;
            stop_reg      <= '0;
            row_reg       <= '0;
            k_reg         <= '0;
            dr_reg        <= '0;
            ec_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
            ts_reg        <= ts_next;
            tp_reg        <= tp_next;
            macc_reg      <= macc_next;
            mc_reg        <= mc_next;
            start_reg     <= start_next;
            stop_reg      <= stop_next;
            row_reg       <= row_next;
            k_reg         <= k_next;
            dr_reg        <= dr_next;
            ec_reg        <= ec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && emit_go)
        begin
            rsp_reg.out_row       <= 3'(row_reg);
            rsp_reg.out_col       <= ec_reg;
            rsp_reg.product_value <= results[ec_reg];
            rsp_reg.last_of_band  <= (row_reg + ROW_W'(1) == stop_reg)
                                     && (32'(ec_reg) == COLS - 1);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_emit_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (row_reg < stop_reg))
        else $error("emitting a row outside the band");

    a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |-> (start_reg <= stop_reg))
        else $error("band start above band stop");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> (state_reg == ST_IDLE))
        else $error("transaction accepted while busy");

endmodule
`default_nettype wire

// ===== design/imm_cell.sv =====
`default_nettype none
module imm_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [2:0]      col_id,
    input  wire imm_pkg::bload_t bload,
    input  wire imm_pkg::link_t  link_in,
    output imm_pkg::link_t       link_out,
    output logic [31:0]          result
);
    import imm_pkg::*;

    logic [31:0]    b_mem [INNER];
    logic           lv_reg;
    logic [K_W-1:0] lk_reg;
    logic [31:0]    la_reg;
    logic [31:0]    prod_reg;
    logic           pv_reg;
    logic           pfirst_reg;
    logic [31:0]    acc_reg;

    // This cell keeps one column of B.
    always_ff @(posedge clk)
    begin
        if (bload.we && bload.col == col_id)
        begin
            b_mem[bload.k] <= bload.data;
        end
        prod_reg   <= link_in.a * b_mem[link_in.k];
        pfirst_reg <= (link_in.k == K_W'(0));
        if (pv_reg)
        begin
            acc_reg <= pfirst_reg ? prod_reg : acc_reg + prod_reg;
        end
        lk_reg <= link_in.k;
        la_reg <= link_in.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            lv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= link_in.valid;
            lv_reg <= link_in.valid;
        end
    end

    assign link_out = {lv_reg, lk_reg, la_reg};
    assign result   = acc_reg;

endmodule
`default_nettype wire
